[design/lapet_pkg.sv]
// ----------------------------------------------------------------------------
// lapet_pkg: shared types and constants of the Laplacian edge threshold block
// Result record, queue push record, configuration register codes, gray
// weights and output levels.
// ----------------------------------------------------------------------------
package lapet_pkg;

  localparam int PIX_W      = 8;
  localparam int X_W        = 10;
  localparam int Y_W        = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int THR_W      = 11;
  localparam int LAP_W      = 12;
  localparam int GSUM_W     = 16;

  // Gray weights in 1/256 units: 0.299, 0.587, 0.114.
  localparam logic [PIX_W-1:0] GRAY_KR = 8'd77;
  localparam logic [PIX_W-1:0] GRAY_KG = 8'd150;
  localparam logic [PIX_W-1:0] GRAY_KB = 8'd29;

  localparam logic [PIX_W-1:0] LEVEL_LOW  = 8'd0;
  localparam logic [PIX_W-1:0] LEVEL_HIGH = 8'd255;

  localparam logic [FW_W-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [FH_W-1:0]  HEIGHT_RESET = 13'd768;
  localparam logic [THR_W-1:0] THR_RESET    = 11'd0;

  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = 2;
  localparam int Q_CNT_W     = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH    = 2'd0,
    CFG_FRAME_HEIGHT   = 2'd1,
    CFG_EDGE_THRESHOLD = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    logic [PIX_W-1:0] level;
    logic             frame_done;
  } result_t;

  typedef struct packed {
    logic    en;
    result_t res;
  } push_t;

endpackage

[design/laplacian_edge_threshold.sv]
// ----------------------------------------------------------------------------
// laplacian_edge_threshold: 3x3 cross Laplacian edge detector with threshold
// RGB pixels in raster order are turned to gray; interior pixels become 0 or
// 255 by comparing the signed Laplacian with a threshold, border pixels pass
// their gray value. Results carry their coordinates.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   in_red, in_green, in_blue
//   out_     output     out_valid / out_stall out_x, out_y, out_level,
//                                             out_frame_done
//   cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One pixel per clock is taken while the result queue has room. A result
// passes the window stage and the result queue, leaving one result per beat.
// Each row gives as many results as pixels except the second row, which gives
// only its first and last pixel, and the last row, where every pixel from the
// third column on gives two; there the input is held to the queue's drain.
// Both line buffers share one MAX_WIDTH x 16 memory, read when a pixel is
// taken and written back when it leaves the window stage.
// Reset clears counters, window and queue; the line memory is not cleared.
// The input stalls while three or more results wait in the four-entry result
// queue and a pixel is held in the window stage.
// ----------------------------------------------------------------------------
module laplacian_edge_threshold #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [lapet_pkg::PIX_W-1:0]        in_red,
  input  logic [lapet_pkg::PIX_W-1:0]        in_green,
  input  logic [lapet_pkg::PIX_W-1:0]        in_blue,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [lapet_pkg::X_W-1:0]          out_x,
  output logic [lapet_pkg::Y_W-1:0]          out_y,
  output logic [lapet_pkg::PIX_W-1:0]        out_level,
  output logic                               out_frame_done,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lapet_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lapet_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int WEW    = $clog2(MAX_WIDTH + 1);
  localparam int HEW    = $clog2(MAX_HEIGHT + 1);
  localparam int LINE_W = 2 * lapet_pkg::PIX_W;

  // Configuration.
  logic [lapet_pkg::FW_W-1:0]         width_r;
  logic [lapet_pkg::FH_W-1:0]         height_r;
  logic signed [lapet_pkg::THR_W-1:0] thresh_r;

  // Position.
  logic [CW-1:0]  col_r;
  logic [RW-1:0]  row_r;
  logic [WEW-1:0] eff_w, w_m1;
  logic [HEW-1:0] eff_h, h_m1;
  logic           last_col, last_row, is_interior, is_border;

  // Window stage.
  logic                       b_valid_r;
  logic [lapet_pkg::PIX_W-1:0] b_red_r, b_green_r, b_blue_r;
  logic [CW-1:0]              b_col_r;
  logic [RW-1:0]              b_row_r;
  logic                       b_int_r, b_bord_r, b_done_r;
  logic                       fwd_r;
  logic [LINE_W-1:0]          fwd_data_r;
  logic [LINE_W-1:0]          mem_rd_r;
  logic [LINE_W-1:0]          line_word, wb_word;
  logic [lapet_pkg::PIX_W-1:0] two_up, one_up, gray;
  logic [lapet_pkg::GSUM_W-1:0] gray_sum;
  logic signed [lapet_pkg::LAP_W-1:0] lap, thr_ext;
  logic [lapet_pkg::PIX_W-1:0] edge_level;
  logic                       in_acc, b_fire, q_room;

  // Window registers: center column is one to the left of the current pixel.
  logic [lapet_pkg::PIX_W-1:0] win_up_r, win_mid_r, win_down_r, win_left_r;

  logic [LINE_W-1:0] line_mem [MAX_WIDTH];

  lapet_pkg::push_t   push_a, push_b;
  lapet_pkg::result_t q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= lapet_pkg::WIDTH_RESET;
      height_r <= lapet_pkg::HEIGHT_RESET;
      thresh_r <= lapet_pkg::THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (lapet_pkg::cfg_idx_t'(cfg_index))
        lapet_pkg::CFG_FRAME_WIDTH:    width_r  <= cfg_data[lapet_pkg::FW_W-1:0];
        lapet_pkg::CFG_FRAME_HEIGHT:   height_r <= cfg_data[lapet_pkg::FH_W-1:0];
        lapet_pkg::CFG_EDGE_THRESHOLD: thresh_r <= cfg_data[lapet_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero size counts as one; a size beyond the maximum saturates.
  always_comb begin
    if (width_r == '0) begin
      eff_w = WEW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      eff_w = WEW'(MAX_WIDTH);
    end else begin
      eff_w = WEW'(width_r);
    end
    if (height_r == '0) begin
      eff_h = HEW'(1);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      eff_h = HEW'(MAX_HEIGHT);
    end else begin
      eff_h = HEW'(height_r);
    end
    w_m1 = eff_w - 1'b1;
    h_m1 = eff_h - 1'b1;
  end

  always_comb begin
    last_col    = (WEW'(col_r) >= w_m1);
    last_row    = (HEW'(row_r) >= h_m1);
    is_interior = (col_r >= CW'(2)) && (WEW'(col_r) <= w_m1) &&
                  (row_r >= RW'(2)) && (HEW'(row_r) <= h_m1);
    is_border   = (col_r == '0) || last_col || (row_r == '0) || last_row;
  end

  assign b_fire   = b_valid_r & q_room;
  assign in_stall = b_valid_r & ~q_room;
  assign in_acc   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (in_acc) begin
      b_valid_r <= 1'b1;
    end else if (b_fire) begin
      b_valid_r <= 1'b0;
    end
  end

  // The pixel ahead may write the same column at the edge this pixel reads it
  // (only with a one-pixel row); its write data is carried along instead.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_red_r    <= in_red;
      b_green_r  <= in_green;
      b_blue_r   <= in_blue;
      b_col_r    <= col_r;
      b_row_r    <= row_r;
      b_int_r    <= is_interior;
      b_bord_r   <= is_border;
      b_done_r   <= last_col & last_row;
      fwd_r      <= b_fire && (b_col_r == col_r);
      fwd_data_r <= wb_word;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem_rd_r <= line_mem[col_r];
    end
    if (b_fire) begin
      line_mem[b_col_r] <= wb_word;
    end
  end

  always_comb begin
    line_word = fwd_r ? fwd_data_r : mem_rd_r;
    two_up    = line_word[LINE_W-1:lapet_pkg::PIX_W];
    one_up    = line_word[lapet_pkg::PIX_W-1:0];
    gray_sum  = lapet_pkg::GSUM_W'(lapet_pkg::GRAY_KR) * lapet_pkg::GSUM_W'(b_red_r)
              + lapet_pkg::GSUM_W'(lapet_pkg::GRAY_KG) * lapet_pkg::GSUM_W'(b_green_r)
              + lapet_pkg::GSUM_W'(lapet_pkg::GRAY_KB) * lapet_pkg::GSUM_W'(b_blue_r);
    gray      = gray_sum[lapet_pkg::GSUM_W-1:lapet_pkg::GSUM_W-lapet_pkg::PIX_W];
    wb_word   = {one_up, gray};
    lap       = $signed({2'b00, win_mid_r, 2'b00})
              - $signed({4'b0000, win_up_r})
              - $signed({4'b0000, win_down_r})
              - $signed({4'b0000, win_left_r})
              - $signed({4'b0000, one_up});
    thr_ext   = {thresh_r[lapet_pkg::THR_W-1], thresh_r};
    edge_level = (lap < thr_ext) ? lapet_pkg::LEVEL_LOW : lapet_pkg::LEVEL_HIGH;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_up_r   <= '0;
      win_mid_r  <= '0;
      win_down_r <= '0;
      win_left_r <= '0;
    end else if (b_fire) begin
      win_up_r   <= two_up;
      win_left_r <= win_mid_r;
      win_mid_r  <= one_up;
      win_down_r <= gray;
    end
  end

  // The interior result for the pixel up and to the left goes first.
  always_comb begin
    push_a.en             = b_fire & b_int_r;
    push_a.res.x          = lapet_pkg::X_W'(b_col_r - 1'b1);
    push_a.res.y          = lapet_pkg::Y_W'(b_row_r - 1'b1);
    push_a.res.level      = edge_level;
    push_a.res.frame_done = 1'b0;
    push_b.en             = b_fire & b_bord_r;
    push_b.res.x          = lapet_pkg::X_W'(b_col_r);
    push_b.res.y          = lapet_pkg::Y_W'(b_row_r);
    push_b.res.level      = gray;
    push_b.res.frame_done = b_done_r;
  end

  lapet_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_a    (push_a),
    .push_b    (push_b),
    .room      (q_room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (q_head)
  );

  assign out_x          = q_head.x;
  assign out_y          = q_head.y;
  assign out_level      = q_head.level;
  assign out_frame_done = q_head.frame_done;

endmodule

[design/lapet_outq.sv]
// ----------------------------------------------------------------------------
// lapet_outq: result queue
// Four-entry queue that takes up to two results per cycle and hands out one
// result per beat on the output channel.
// ----------------------------------------------------------------------------
module lapet_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  lapet_pkg::push_t    push_a,
  input  lapet_pkg::push_t    push_b,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output lapet_pkg::result_t  head
);

  lapet_pkg::result_t                   entry_r [lapet_pkg::QUEUE_DEPTH];
  logic [lapet_pkg::Q_PTR_W-1:0]        wr_ptr_r, wr_ptr_nxt, wr_next;
  logic [lapet_pkg::Q_PTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [lapet_pkg::Q_CNT_W-1:0]        count_r, count_nxt;
  logic [1:0]                           n_push;
  logic                                 pop;

  assign n_push    = {1'b0, push_a.en} + {1'b0, push_b.en};
  assign out_valid = (count_r != '0);
  assign pop       = out_valid & ~out_stall;
  assign head      = entry_r[rd_ptr_r];
  // Room for two pushes is judged on the registered count alone, so the
  // input side never waits on the output stall combinationally.
  assign room      = (count_r <= lapet_pkg::Q_CNT_W'(lapet_pkg::QUEUE_DEPTH - 2));
  assign wr_next   = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + lapet_pkg::Q_PTR_W'(n_push);
    rd_ptr_nxt = rd_ptr_r + lapet_pkg::Q_PTR_W'(pop);
    count_nxt  = count_r + lapet_pkg::Q_CNT_W'(n_push) - lapet_pkg::Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_a.en | push_b.en) begin
      entry_r[wr_ptr_r] <= push_a.en ? push_a.res : push_b.res;
    end
    if (push_a.en & push_b.en) begin
      entry_r[wr_next] <= push_b.res;
    end
  end

endmodule

[design/lapet_checker.sv]
// ----------------------------------------------------------------------------
// lapet_checker: port-level checks of the Laplacian edge threshold block
// Watches the handshakes over time; bound to the top level below.
// ----------------------------------------------------------------------------
module lapet_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [lapet_pkg::X_W-1:0]     out_x,
  input logic [lapet_pkg::Y_W-1:0]     out_y,
  input logic [lapet_pkg::PIX_W-1:0]   out_level,
  input logic                          out_frame_done
);

  // Reset leaves no result pending and the input open.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("block not idle after reset");

  // With no result waiting, the input must never be held off.
  a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while no result is pending");

  // A held result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_x) && $stable(out_y) &&
                                  $stable(out_level) && $stable(out_frame_done)))
    else $error("stalled result beat changed");

  // An input beat held off must stay offered by the source.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> in_valid)
    else $error("input beat withdrawn while stalled");

endmodule

bind laplacian_edge_threshold lapet_checker u_lapet_checker (.*);
